>>> sv/lbls_pkg.sv
`default_nettype none

package lbls_pkg;

    // Input transaction commands.
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SUBMIT   = 2'd1,
        CMD_RX_START = 2'd2,
        CMD_RX_DONE  = 2'd3
    } t_cmd;

    // Result transaction kinds.
    typedef enum logic [1:0] {
        KIND_ACCEPTED  = 2'd0,
        KIND_REJECTED  = 2'd1,
        KIND_LAUNCHED  = 2'd2,
        KIND_DELIVERED = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TE_TICKS        = 2'd0;
    localparam logic [1:0] CFG_BACKWARD_GAP_TE = 2'd1;
    localparam logic [1:0] CFG_FORWARD_GAP_TE  = 2'd2;
    localparam logic [1:0] CFG_RESP_WINDOW_TE  = 2'd3;

    // Register reset values.
    localparam logic [15:0] TE_TICKS_RESET     = 16'd417;
    localparam logic [7:0]  BACKWARD_GAP_RESET = 8'd3;
    localparam logic [7:0]  FORWARD_GAP_RESET  = 8'd22;
    localparam logic [7:0]  RESP_WINDOW_RESET  = 8'd22;

    // A reception spans the frame bits plus start and stop overhead, in bits.
    localparam logic [6:0] RX_OVERHEAD_BITS = 7'd3;

    // One frame as held in the transmit queue.
    typedef struct packed {
        logic [31:0] data;
        logic [5:0]  size;
        logic [7:0]  flags;
        logic        backward;
        logic [7:0]  tag;
    } t_frame;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] frame_data;
        logic [5:0]  frame_size;
        logic [7:0]  frame_flags;
        logic        frame_backward;
        logic [7:0]  frame_tag;
    } t_in_item;

    typedef struct packed {
        t_kind       result_kind;
        logic [31:0] out_data;
        logic [5:0]  out_size;
        logic [7:0]  out_flags;
        logic [7:0]  out_tag;
        logic        is_echo;
        logic        is_collision;
        logic        is_backward;
        logic [3:0]  queue_count;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/lbls_tx_queue.sv
`default_nettype none

module lbls_tx_queue
    import lbls_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire t_frame                 i_push_frame,
    input  wire                         i_pop,
    output t_frame                      o_head_frame,
    output logic [$clog2(DEPTH+1)-1:0]  o_count,
    output logic                        o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame          r_mem [DEPTH];
    t_frame          r_head_frame;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;

    assign o_head_frame = r_head_frame;
    assign o_count      = r_count;
    assign o_full       = (r_count == CW'(DEPTH));

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Frame storage; the tail entry is written on each push.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_frame;
        end
    end

    // Registered head read; a frame written into the next head slot is passed straight on.
    always_ff @(posedge i_clk) begin
        if (i_push && (r_tail == n_head)) begin
            r_head_frame <= i_push_frame;
        end else begin
            r_head_frame <= r_mem[n_head];
        end
    end

endmodule

`default_nettype wire

>>> sv/lighting_bus_link_sequencer_core.sv
`default_nettype none

// Link-layer sequencer for a two-wire lighting bus. Each input transaction is a
// tick, a frame submission, a receive-start notice or a received frame; it is
// captured in an input register, worked through against the queue and timing
// state once the output register is free or drained, and its result (if any) is
// placed in an output register. One transaction is taken every cycle while
// results are drained, so the sustained rate is one item per cycle, and each
// result reaches the output register straight from the input register; the rate
// is set by the state update of the single processing stage, which every item
// passes through in order. Configuration writes are always ready and take effect
// on the next cycle; they are to be made only while the block is idle.
module lighting_bus_link_sequencer_core
    import lbls_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 8,
    parameter int MAX_FRAME_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire t_in_item i_in,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data
);

    localparam int          CW       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [5:0]  MaxBits  = 6'(MAX_FRAME_BITS);

    // Configuration registers.
    logic [15:0] r_te_ticks;
    logic [7:0]  r_backward_gap;
    logic [7:0]  r_forward_gap;
    logic [7:0]  r_resp_window;

    // Input stage.
    logic        r_in_valid;
    t_in_item    r_in;
    logic [23:0] r_rx_span;
    logic [22:0] rx_bits_ticks;

    // Output stage.
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // Link state.
    t_frame      r_cur, n_cur;
    logic        r_sending, n_sending;
    logic        r_bus_rx, n_bus_rx;
    logic        r_awaiting, n_awaiting;
    logic [31:0] r_deadline, n_deadline;
    logic [31:0] r_time, n_time;
    logic [31:0] r_last_rx, n_last_rx;

    // Queue interface.
    logic          q_push, q_pop, q_full;
    t_frame        q_head, q_push_frame;
    logic [CW-1:0] q_count;

    logic        proc;
    logic [23:0] gap_ticks;
    logic [23:0] window_ticks;
    logic [31:0] time_tick;
    logic [31:0] rx_start;
    logic [31:0] since_rx;
    logic [31:0] to_deadline;
    logic [7:0]  gap_te;

    assign o_cfg_ready = 1'b1;
    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_te_ticks     <= TE_TICKS_RESET;
            r_backward_gap <= BACKWARD_GAP_RESET;
            r_forward_gap  <= FORWARD_GAP_RESET;
            r_resp_window  <= RESP_WINDOW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TE_TICKS:        r_te_ticks     <= i_cfg_data;
                CFG_BACKWARD_GAP_TE: r_backward_gap <= i_cfg_data[7:0];
                CFG_FORWARD_GAP_TE:  r_forward_gap  <= i_cfg_data[7:0];
                CFG_RESP_WINDOW_TE:  r_resp_window  <= i_cfg_data[7:0];
            endcase
        end
    end

    // Input capture; the reception span (size + 3) * 2 TE is formed here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    assign rx_bits_ticks = 23'({1'b0, i_in.frame_size} + RX_OVERHEAD_BITS)
                           * 23'(r_te_ticks);

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in      <= i_in;
            r_rx_span <= {rx_bits_ticks, 1'b0};
        end
    end

    // Timing arithmetic for the transaction in the input register.
    assign gap_te       = q_head.backward ? r_backward_gap : r_forward_gap;
    assign gap_ticks    = 24'(gap_te) * 24'(r_te_ticks);
    assign window_ticks = 24'(r_resp_window) * 24'(r_te_ticks);
    assign time_tick    = r_time + 32'd1;
    assign since_rx     = time_tick - r_last_rx;
    assign rx_start     = r_time - {8'd0, r_rx_span};
    assign to_deadline  = r_deadline - rx_start;

    assign q_push_frame = '{data:     r_in.frame_data,
                            size:     r_in.frame_size,
                            flags:    r_in.frame_flags,
                            backward: r_in.frame_backward,
                            tag:      r_in.frame_tag};

    // Processing of one transaction: state update and result formation.
    always_comb begin
        n_cur       = r_cur;
        n_sending   = r_sending;
        n_bus_rx    = r_bus_rx;
        n_awaiting  = r_awaiting;
        n_deadline  = r_deadline;
        n_time      = r_time;
        n_last_rx   = r_last_rx;
        q_push      = 1'b0;
        q_pop       = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (proc) begin
            n_out_valid = 1'b0;
            n_out       = '0;
            n_out.queue_count = 4'(q_count);
            unique case (r_in.command)
                CMD_TICK: begin
                    n_time = time_tick;
                    if ((q_count != '0) && !r_sending && !r_bus_rx
                            && (since_rx >= {8'd0, gap_ticks})) begin
                        q_pop       = 1'b1;
                        n_cur       = q_head;
                        n_sending   = 1'b1;
                        n_awaiting  = 1'b0;
                        n_out_valid = 1'b1;
                        n_out.result_kind = KIND_LAUNCHED;
                        n_out.out_data    = q_head.data;
                        n_out.out_size    = q_head.size;
                        n_out.out_flags   = q_head.flags;
                        n_out.out_tag     = q_head.tag;
                        n_out.is_backward = q_head.backward;
                        n_out.queue_count = 4'(q_count - 1'b1);
                    end
                end
                CMD_SUBMIT: begin
                    n_out_valid = 1'b1;
                    if ((r_in.frame_size > MaxBits) || q_full) begin
                        n_out.result_kind = KIND_REJECTED;
                    end else begin
                        q_push            = 1'b1;
                        n_out.result_kind = KIND_ACCEPTED;
                        n_out.queue_count = 4'(q_count + 1'b1);
                    end
                end
                CMD_RX_START: begin
                    n_bus_rx = 1'b1;
                end
                CMD_RX_DONE: begin
                    n_out_valid = 1'b1;
                    n_out.result_kind = KIND_DELIVERED;
                    n_out.out_data    = r_in.frame_data;
                    n_out.out_size    = r_in.frame_size;
                    n_out.out_flags   = r_in.frame_flags;
                    n_out.out_tag     = r_in.frame_tag;
                    // A reply that started by the deadline counts as backward.
                    if (r_awaiting) begin
                        if (!to_deadline[31]) begin
                            n_out.is_backward = 1'b1;
                            n_out.out_tag     = r_cur.tag;
                        end
                        n_awaiting = 1'b0;
                    end
                    // While sending, the reception is our echo or a collision.
                    if (r_sending) begin
                        n_out.out_tag = r_cur.tag;
                        if ((r_cur.data == r_in.frame_data)
                                && (r_cur.size == r_in.frame_size)) begin
                            n_out.out_flags = r_in.frame_flags | r_cur.flags;
                            n_out.is_echo   = 1'b1;
                            if (r_cur.backward) begin
                                n_out.is_backward = 1'b1;
                            end
                            n_awaiting = 1'b1;
                            n_deadline = r_time + {8'd0, window_ticks};
                        end else begin
                            n_out.is_collision = 1'b1;
                            n_out.out_data     = '0;
                            n_out.out_size     = '0;
                        end
                    end
                    n_sending = 1'b0;
                    n_bus_rx  = 1'b0;
                    n_last_rx = r_time;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_sending   <= 1'b0;
            r_bus_rx    <= 1'b0;
            r_awaiting  <= 1'b0;
            r_deadline  <= '0;
            r_time      <= '0;
            r_last_rx   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_sending   <= n_sending;
            r_bus_rx    <= n_bus_rx;
            r_awaiting  <= n_awaiting;
            r_deadline  <= n_deadline;
            r_time      <= n_time;
            r_last_rx   <= n_last_rx;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    lbls_tx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_tx_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_frame (q_push_frame),
        .i_pop        (q_pop),
        .o_head_frame (q_head),
        .o_count      (q_count),
        .o_full       (q_full)
    );

endmodule

`default_nettype wire
